@@ rtl/cdd_pkg.sv @@
// Shared types, constants and calendar tables for the calendar date difference block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cdd_pkg;

    localparam int unsigned MAX_YEAR = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int ORD_W   = 3;
    localparam int WD_W    = 3;
    localparam int DNUM_W  = 23;
    localparam int DIFF_W  = 22;
    localparam int NSTAGE  = 6;

    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;
    localparam logic [15:0] RECIP_7   = 16'd37450;
    localparam int          SHIFT_7   = 18;

    localparam logic [WD_W-1:0]    WD_INVALID = 3'd7;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

    typedef enum logic [1:0] {
        OP_PLAIN_PLAIN = 2'd0,
        OP_SECOND_NTH  = 2'd1,
        OP_FIRST_NTH   = 2'd2,
        OP_BOTH_NTH    = 2'd3
    } op_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [ORD_W-1:0]   ordinal;
        logic [WD_W-1:0]    weekday;
    } date_t;

    typedef struct packed {
        logic in_ld;
        logic s1_ld;
        logic s2_ld;
        logic s3_ld;
        logic s4_ld;
        logic out_ld;
    } stage_en_t;

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] days_before_mod7(input logic [MONTH_W-1:0] m);
        logic [2:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cdd_ctrl.sv @@
// Pipeline occupancy and load enables for the calendar date difference block.
// Depends on cdd_pkg for the stage count and the enable struct.
`default_nettype none

module cdd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output cdd_pkg::stage_en_t     en
);

    logic [cdd_pkg::NSTAGE-1:0] valid_reg;
    logic [cdd_pkg::NSTAGE-1:0] valid_next;
    logic [cdd_pkg::NSTAGE:0]   ready;

    always_comb
    begin
        ready[cdd_pkg::NSTAGE] = m_tready;
        for (int k = cdd_pkg::NSTAGE - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        for (int k = 0; k < cdd_pkg::NSTAGE; k++)
        begin
            if (ready[k])
            begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready  = ready[0];
    assign m_tvalid  = valid_reg[cdd_pkg::NSTAGE-1];
    assign en.in_ld  = ready[0];
    assign en.s1_ld  = ready[1];
    assign en.s2_ld  = ready[2];
    assign en.s3_ld  = ready[3];
    assign en.s4_ld  = ready[4];
    assign en.out_ld = ready[5];

endmodule

`default_nettype wire

@@ rtl/cdd_date.sv @@
// Four-stage datapath that turns one date into its day number and a validity flag.
// Depends on cdd_pkg for field widths, reciprocal constants and month tables.
`default_nettype none

module cdd_date #(
    parameter int unsigned MAX_YEAR = cdd_pkg::MAX_YEAR
) (
    input  wire logic                         clk,
    input  wire cdd_pkg::stage_en_t           en,
    input  wire logic                         nth,
    input  wire cdd_pkg::date_t               dt,
    output logic                              ok,
    output logic [cdd_pkg::DNUM_W-1:0]        dnum
);

    localparam int DW = cdd_pkg::DNUM_W;

    // stage 1: century quotients, range checks
    logic [13:0] p_s1;
    logic [26:0] prod_p, prod_y;
    logic        ok_s1;

    logic [13:0] y_s1_reg, p_s1_reg;
    logic [7:0]  qp_s1_reg, qy_s1_reg;
    logic [3:0]  m_s1_reg;
    logic        ok_s1_reg, nth_s1_reg;
    logic [4:0]  d_s1_reg;
    logic [2:0]  ord_s1_reg, wd_s1_reg;

    assign p_s1   = dt.year - 14'd1;
    assign prod_p = 27'(p_s1) * 27'(cdd_pkg::RECIP_100);
    assign prod_y = 27'(dt.year) * 27'(cdd_pkg::RECIP_100);
    assign ok_s1  = (dt.year != '0) && (32'(dt.year) <= MAX_YEAR)
                  && (dt.month != '0) && (dt.month <= cdd_pkg::MONTH_DEC);

    always_ff @(posedge clk)
    begin
        if (en.s1_ld)
        begin
            y_s1_reg   <= dt.year;
            p_s1_reg   <= p_s1;
            qp_s1_reg  <= 8'(prod_p >> cdd_pkg::SHIFT_100);
            qy_s1_reg  <= 8'(prod_y >> cdd_pkg::SHIFT_100);
            m_s1_reg   <= dt.month;
            ok_s1_reg  <= ok_s1;
            nth_s1_reg <= nth;
            d_s1_reg   <= dt.day;
            ord_s1_reg <= dt.ordinal;
            wd_s1_reg  <= dt.weekday;
        end
    end

    // stage 2: leap year, month base, year weekday sum
    logic          cent, leap, adj;
    logic [15:0]   s_full;
    logic [DW-1:0] base_s2;

    logic [14:0]   s_s2_reg;
    logic [DW-1:0] base_s2_reg;
    logic [4:0]    len_s2_reg;
    logic [2:0]    mofs_s2_reg;
    logic          adj_s2_reg, ok_s2_reg, nth_s2_reg;
    logic [4:0]    d_s2_reg;
    logic [2:0]    ord_s2_reg, wd_s2_reg;

    assign cent    = ({1'b0, y_s1_reg} == (15'(qy_s1_reg) * 15'd100));
    assign leap    = ((y_s1_reg[1:0] == 2'd0) && !cent) || (cent && (qy_s1_reg[1:0] == 2'd0));
    assign adj     = (m_s1_reg > cdd_pkg::MONTH_FEB) && leap;
    assign s_full  = 16'(p_s1_reg) + 16'(p_s1_reg >> 2) - 16'(qp_s1_reg) + 16'(qp_s1_reg >> 2);
    assign base_s2 = DW'(p_s1_reg) * DW'(364) + DW'(s_full)
                   + DW'(cdd_pkg::days_before(m_s1_reg)) + DW'(adj);

    always_ff @(posedge clk)
    begin
        if (en.s2_ld)
        begin
            s_s2_reg    <= s_full[14:0];
            base_s2_reg <= base_s2;
            len_s2_reg  <= cdd_pkg::month_len(m_s1_reg)
                         + 5'((m_s1_reg == cdd_pkg::MONTH_FEB) && leap);
            mofs_s2_reg <= cdd_pkg::days_before_mod7(m_s1_reg);
            adj_s2_reg  <= adj;
            ok_s2_reg   <= ok_s1_reg;
            nth_s2_reg  <= nth_s1_reg;
            d_s2_reg    <= d_s1_reg;
            ord_s2_reg  <= ord_s1_reg;
            wd_s2_reg   <= wd_s1_reg;
        end
    end

    // stage 3: year sum modulo 7
    logic [30:0]   prod7;
    logic [11:0]   q7;
    logic [14:0]   r7_full;

    logic [2:0]    r7_s3_reg;
    logic [DW-1:0] base_s3_reg;
    logic [4:0]    len_s3_reg;
    logic [2:0]    mofs_s3_reg;
    logic          adj_s3_reg, ok_s3_reg, nth_s3_reg;
    logic [4:0]    d_s3_reg;
    logic [2:0]    ord_s3_reg, wd_s3_reg;

    assign prod7   = 31'(s_s2_reg) * 31'(cdd_pkg::RECIP_7);
    assign q7      = 12'(prod7 >> cdd_pkg::SHIFT_7);
    assign r7_full = s_s2_reg - 15'(q7) * 15'd7;

    always_ff @(posedge clk)
    begin
        if (en.s3_ld)
        begin
            r7_s3_reg   <= r7_full[2:0];
            base_s3_reg <= base_s2_reg;
            len_s3_reg  <= len_s2_reg;
            mofs_s3_reg <= mofs_s2_reg;
            adj_s3_reg  <= adj_s2_reg;
            ok_s3_reg   <= ok_s2_reg;
            nth_s3_reg  <= nth_s2_reg;
            d_s3_reg    <= d_s2_reg;
            ord_s3_reg  <= ord_s2_reg;
            wd_s3_reg   <= wd_s2_reg;
        end
    end

    // stage 4: day of month, existence check, day number
    logic [3:0] t_sum, dd;
    logic [2:0] start, d0;
    logic [5:0] day_nth, day;
    logic       form_ok;

    always_comb
    begin
        t_sum = 4'(r7_s3_reg) + 4'(mofs_s3_reg) + 4'(adj_s3_reg) + 4'd1;
        if (t_sum >= 4'd14)
        begin
            start = 3'(t_sum - 4'd14);
        end
        else if (t_sum >= 4'd7)
        begin
            start = 3'(t_sum - 4'd7);
        end
        else
        begin
            start = t_sum[2:0];
        end
        dd      = 4'(wd_s3_reg) + 4'd7 - 4'(start);
        d0      = (dd >= 4'd7) ? 3'(dd - 4'd7) : dd[2:0];
        day_nth = 6'd1 + 6'(d0) + 6'(ord_s3_reg - 3'd1) * 6'd7;
        day     = nth_s3_reg ? day_nth : 6'(d_s3_reg);
        form_ok = nth_s3_reg ? ((ord_s3_reg != '0) && (wd_s3_reg != cdd_pkg::WD_INVALID))
                             : (d_s3_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4_ld)
        begin
            ok   <= ok_s3_reg && form_ok && (day <= 6'(len_s3_reg));
            dnum <= base_s3_reg + DW'(day);
        end
    end

endmodule

`default_nettype wire

@@ rtl/calendar_date_difference.sv @@
// Top level of the calendar date difference block: input register, two date datapaths,
// difference stage and output register. Depends on cdd_pkg, cdd_ctrl and cdd_date.
//
// Usage: the slave channel takes one word per pair of dates; s_tuser carries the
// operation (which dates are given as the Nth weekday of a month), s_tdata the two
// dates. The master channel returns one word per input word, in order: m_tuser[0]
// is set when both dates exist, m_tdata holds the absolute day difference (zero
// when either date does not exist).
// From acceptance to m_tvalid the word passes the input register, four date stages
// and the output register. Throughput: one word per cycle, sustained while m_tready
// stays high; every stage holds one word and advances as soon as the stage after it
// frees up.
// Stall: when m_tready is low the pipeline keeps filling its empty stages and
// drops s_tready only once all six stages hold a word; nothing is lost or repeated.
// Reset: rst_n low empties the pipeline at once; m_tvalid goes low and s_tready
// high, and the block takes words from the first edge after release.
`default_nettype none

module calendar_date_difference #(
    parameter int unsigned MAX_YEAR = cdd_pkg::MAX_YEAR
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [13:0] first_year, [17:14] first_month, [22:18] first_day, [25:23] first_ordinal,
    // [28:26] first_weekday, [42:29] second_year, [46:43] second_month,
    // [51:47] second_day, [54:52] second_ordinal, [57:55] second_weekday, [63:58] zero
    input  wire logic [63:0] s_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [21:0] day_difference, [23:22] zero
    output logic [23:0]      m_tdata,
    // [0] valid_res
    output logic [0:0]       m_tuser
);

    cdd_pkg::stage_en_t en;

    cdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .en       (en)
    );

    cdd_pkg::op_t   op_reg;
    cdd_pkg::date_t first_reg, second_reg;
    logic           nth_first, nth_second;

    always_ff @(posedge clk)
    begin
        if (en.in_ld)
        begin
            op_reg     <= cdd_pkg::op_t'(s_tuser);
            first_reg  <= cdd_pkg::date_t'({s_tdata[13:0], s_tdata[17:14], s_tdata[22:18],
                                            s_tdata[25:23], s_tdata[28:26]});
            second_reg <= cdd_pkg::date_t'({s_tdata[42:29], s_tdata[46:43], s_tdata[51:47],
                                            s_tdata[54:52], s_tdata[57:55]});
        end
    end

    assign nth_first  = (op_reg == cdd_pkg::OP_FIRST_NTH) || (op_reg == cdd_pkg::OP_BOTH_NTH);
    assign nth_second = (op_reg == cdd_pkg::OP_SECOND_NTH) || (op_reg == cdd_pkg::OP_BOTH_NTH);

    logic                        ok_a, ok_b;
    logic [cdd_pkg::DNUM_W-1:0]  dnum_a, dnum_b;

    cdd_date #(
        .MAX_YEAR (MAX_YEAR)
    ) u_first (
        .clk  (clk),
        .en   (en),
        .nth  (nth_first),
        .dt   (first_reg),
        .ok   (ok_a),
        .dnum (dnum_a)
    );

    cdd_date #(
        .MAX_YEAR (MAX_YEAR)
    ) u_second (
        .clk  (clk),
        .en   (en),
        .nth  (nth_second),
        .dt   (second_reg),
        .ok   (ok_b),
        .dnum (dnum_b)
    );

    logic                        both_ok;
    logic [cdd_pkg::DNUM_W-1:0]  span_full;
    logic [cdd_pkg::DIFF_W-1:0]  diff;

    assign both_ok   = ok_a && ok_b;
    assign span_full = !both_ok ? '0
                     : (dnum_a > dnum_b) ? (dnum_a - dnum_b) : (dnum_b - dnum_a);
    assign diff      = span_full[cdd_pkg::DIFF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en.out_ld)
        begin
            m_tuser <= both_ok;
            m_tdata <= 24'(diff);
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result carries a nonzero difference");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata <= 24'd3652058)
        else $error("day difference beyond calendar range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while output stage can drain");
`endif

endmodule

`default_nettype wire

@@ dv/date_diff_checker.sv @@
// Checker for calendar_date_difference: watches both stream channels, predicts each
// day difference from the accepted dates and compares it with the returned word.
// Depends on cdd_pkg for field widths, the operation encoding and calendar limits.
`timescale 1ns / 100ps

module date_diff_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [28:0] first date, [57:29] second date, [63:58] zero
    input  wire logic [63:0] s_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [21:0] day_difference, [23:22] zero
    input  wire logic [23:0] m_tdata,
    // [0] valid_res
    input  wire logic [0:0]  m_tuser,
    output int unsigned      mismatch_count,
    output int unsigned      backlog
);

    typedef struct packed {
        logic                       ok;
        logic [cdd_pkg::DIFF_W-1:0] span;
    } span_t;

    span_t       span_q[$];
    int unsigned fails = 0;
    int unsigned days_ahead [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

    function automatic cdd_pkg::date_t unpack_date(input logic [28:0] raw);
        cdd_pkg::date_t d;
        d.year    = raw[13:0];
        d.month   = raw[17:14];
        d.day     = raw[22:18];
        d.ordinal = raw[25:23];
        d.weekday = raw[28:26];
        return d;
    endfunction

    function automatic bit day_number(input bit nth, input cdd_pkg::date_t d,
                                      output int unsigned dnum);
        int unsigned y;
        int unsigned m;
        int unsigned p;
        int unsigned len;
        int unsigned base;
        int unsigned lead;
        int unsigned dom;
        bit          leap;
        dnum = 0;
        y = d.year;
        m = d.month;
        if (y == 0 || y > cdd_pkg::MAX_YEAR || m == 0 || m > cdd_pkg::MONTH_DEC)
            return 0;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        p = y - 1;
        base = 365 * p + p / 4 - p / 100 + p / 400 + days_ahead[m - 1]
             + ((m > cdd_pkg::MONTH_FEB && leap) ? 1 : 0);
        len = days_ahead[m] - days_ahead[m - 1]
            + ((m == cdd_pkg::MONTH_FEB && leap) ? 1 : 0);
        if (!nth)
            dom = d.day;
        else
        begin
            if (d.ordinal == 0 || d.weekday == cdd_pkg::WD_INVALID)
                return 0;
            // weekday of the 1st: day number 1 is a Monday
            lead = (base % 7 + 1) % 7;
            dom = 1 + (d.weekday + 7 - lead) % 7 + 7 * (d.ordinal - 1);
        end
        if (dom == 0 || dom > len)
            return 0;
        dnum = base + dom;
        return 1;
    endfunction

    function automatic span_t predict_span(input logic [1:0] op_bits, input logic [63:0] word);
        cdd_pkg::op_t op;
        span_t        s;
        int unsigned  da;
        int unsigned  db;
        int unsigned  gap;
        bit           ok_a;
        bit           ok_b;
        op = cdd_pkg::op_t'(op_bits);
        ok_a = day_number(op == cdd_pkg::OP_FIRST_NTH || op == cdd_pkg::OP_BOTH_NTH,
                          unpack_date(word[28:0]), da);
        ok_b = day_number(op == cdd_pkg::OP_SECOND_NTH || op == cdd_pkg::OP_BOTH_NTH,
                          unpack_date(word[57:29]), db);
        s.ok = ok_a && ok_b;
        s.span = '0;
        if (s.ok)
        begin
            gap = (da > db) ? (da - db) : (db - da);
            s.span = gap[cdd_pkg::DIFF_W-1:0];
        end
        return s;
    endfunction

    always @(posedge clk)
    begin : watch
        span_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                span_q.push_back(predict_span(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (span_q.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: unexpected word valid_res=%0d day_difference=%0d",
                                 $realtime, m_tuser[0], m_tdata[21:0]);
                    fails++;
                end
                else
                begin
                    want = span_q.pop_front();
                    if (m_tuser[0] !== want.ok || m_tdata !== {2'b00, want.span})
                    begin
                        if (fails < 10)
                            $display({"%0t: mismatch valid_res exp %0d got %0d, ",
                                      "day_difference exp %0d got %0d (raw %h)"},
                                     $realtime, want.ok, m_tuser[0], want.span,
                                     m_tdata[21:0], m_tdata);
                        fails++;
                    end
                end
            end
        end
        mismatch_count <= fails;
        backlog <= span_q.size();
    end

endmodule

@@ dv/calendar_date_difference_test.sv @@
// Testbench top for calendar_date_difference: clock, reset, directed and random date
// pairs with random idling on both channels, and the verdict.
// Depends on cdd_pkg, the block itself and date_diff_checker.
`timescale 1ns / 100ps

module calendar_date_difference_test;

    localparam int unsigned WORD_COUNT = 1400;
    localparam int unsigned CALM_TAIL  = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    int unsigned mismatch_count;
    int unsigned backlog;
    bit          calm = 1'b0;
    int unsigned gap_odds = 0;

    calendar_date_difference u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    date_diff_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .backlog        (backlog)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic cdd_pkg::date_t make_date(input int unsigned y, input int unsigned m,
                                                 input int unsigned d, input int unsigned o,
                                                 input int unsigned w);
        cdd_pkg::date_t r;
        r.year    = y[cdd_pkg::YEAR_W-1:0];
        r.month   = m[cdd_pkg::MONTH_W-1:0];
        r.day     = d[cdd_pkg::DAY_W-1:0];
        r.ordinal = o[cdd_pkg::ORD_W-1:0];
        r.weekday = w[cdd_pkg::WD_W-1:0];
        return r;
    endfunction

    function automatic cdd_pkg::date_t random_date(input bit noisy);
        int unsigned y;
        int unsigned d;
        int unsigned o;
        if (noisy)
            return make_date($urandom_range(0, 16383), $urandom_range(0, 15),
                             $urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 7));
        // lean on century years to hit the leap exceptions
        y = ($urandom_range(0, 4) == 0) ? 100 * $urandom_range(1, 99)
                                        : $urandom_range(1, cdd_pkg::MAX_YEAR);
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
        o = ($urandom_range(0, 5) == 0) ? 5 : $urandom_range(1, 4);
        return make_date(y, $urandom_range(1, 12), d, o, $urandom_range(0, 6));
    endfunction

    task automatic send_dates(input cdd_pkg::op_t op, input cdd_pkg::date_t a,
                              input cdd_pkg::date_t b);
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, b.weekday, b.ordinal, b.day, b.month, b.year,
                    a.weekday, a.ordinal, a.day, a.month, a.year};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge clk); while (backlog != 0);
    endtask

    initial
    begin
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(1, 1, 1, 0, 0),
                   make_date(9999, 12, 31, 0, 0));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(9999, 12, 31, 7, 7),
                   make_date(1, 1, 1, 7, 7));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2024, 2, 29, 1, 1),
                   make_date(2024, 2, 29, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(1900, 2, 29, 1, 1),
                   make_date(2000, 2, 29, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2000, 2, 29, 1, 1),
                   make_date(2100, 3, 1, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(0, 6, 15, 1, 1),
                   make_date(2000, 6, 15, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2000, 6, 15, 1, 1),
                   make_date(10000, 1, 1, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(16383, 15, 31, 7, 7),
                   make_date(5, 5, 5, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2020, 0, 10, 1, 1),
                   make_date(2020, 1, 10, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2020, 1, 10, 1, 1),
                   make_date(2020, 13, 10, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2020, 3, 0, 1, 1),
                   make_date(2020, 3, 1, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2023, 4, 31, 1, 1),
                   make_date(2023, 5, 31, 1, 1));
        send_dates(cdd_pkg::OP_PLAIN_PLAIN, make_date(2023, 1, 31, 0, 7),
                   make_date(2023, 12, 31, 7, 0));
        send_dates(cdd_pkg::OP_SECOND_NTH, make_date(2024, 1, 1, 0, 0),
                   make_date(2024, 1, 0, 1, 1));
        send_dates(cdd_pkg::OP_SECOND_NTH, make_date(1, 1, 1, 0, 0),
                   make_date(9999, 12, 31, 4, 6));
        send_dates(cdd_pkg::OP_FIRST_NTH, make_date(2022, 7, 9, 2, 7),
                   make_date(2022, 7, 9, 2, 3));
        send_dates(cdd_pkg::OP_FIRST_NTH, make_date(2022, 7, 9, 0, 3),
                   make_date(2022, 7, 9, 2, 3));
        send_dates(cdd_pkg::OP_FIRST_NTH, make_date(2022, 8, 31, 1, 0),
                   make_date(1999, 12, 31, 5, 5));
        send_dates(cdd_pkg::OP_BOTH_NTH, make_date(2023, 2, 0, 5, 0),
                   make_date(2023, 2, 0, 4, 0));
        send_dates(cdd_pkg::OP_BOTH_NTH, make_date(2024, 2, 0, 5, 4),
                   make_date(2020, 2, 0, 5, 6));
        send_dates(cdd_pkg::OP_BOTH_NTH, make_date(2021, 5, 31, 7, 2),
                   make_date(2021, 5, 31, 1, 2));
        send_dates(cdd_pkg::OP_BOTH_NTH, make_date(1, 1, 0, 1, 1),
                   make_date(9999, 12, 0, 5, 5));
        send_dates(cdd_pkg::OP_BOTH_NTH, make_date(0, 0, 0, 1, 1),
                   make_date(9999, 15, 0, 1, 1));
        drain();

        for (int unsigned i = 0; i < WORD_COUNT; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 2;
                    default: gap_odds = 6;
                endcase
            end
            if (i == WORD_COUNT - CALM_TAIL)
                calm = 1'b1;
            send_dates(cdd_pkg::op_t'($urandom_range(0, 3)),
                       random_date($urandom_range(0, 7) == 0),
                       random_date($urandom_range(0, 7) == 0));
            if (i == 300 || i == 700)
                drain();
        end

        drain();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
